// ===== rtl/wpi_pkg.sv =====
package wpi_pkg;

    // store geometry
    localparam int WAYPOINTS  = 256;
    localparam int ADDR_W     = $clog2(WAYPOINTS);

    // field widths
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int CNT_W      = 9;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W    = 3 * COORD_W;

    // arithmetic widths
    localparam int MAG_W      = COORD_W + 1;      // |target - current|
    localparam int PROD_W     = 2 * MAG_W;        // square or |d| * step
    localparam int ROOT_W     = MAG_W;            // floor(sqrt(sum of squares))
    localparam int QUO_W      = 64;               // |d| * step / len
    localparam int QC_W       = 34;               // clamped move
    localparam int NV_W       = 36;               // new coordinate before saturation
    localparam logic [QC_W-1:0] MOVE_CAP = QC_W'(64'h2_0000_0000);

    // request kinds
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_LOAD    = 2'd0;
    localparam kind_t KIND_RESTART = 2'd1;
    localparam kind_t KIND_STEP    = 2'd2;

    // result status
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_MOVING   = 2'd0;
    localparam status_t ST_REACHED  = 2'd1;
    localparam status_t ST_FINISHED = 2'd2;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_START_X = 3'd0;
    localparam cfg_idx_t REG_START_Y = 3'd1;
    localparam cfg_idx_t REG_START_Z = 3'd2;
    localparam cfg_idx_t REG_STEP    = 3'd3;
    localparam cfg_idx_t REG_COUNT   = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(65536);
    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(1);

endpackage

// ===== rtl/wpi_cmd_if.sv =====
interface wpi_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [wpi_pkg::KIND_W-1:0]          kind;
    logic [wpi_pkg::ADDR_W-1:0]          waypoint_index;
    logic signed [wpi_pkg::COORD_W-1:0]  wp_x;
    logic signed [wpi_pkg::COORD_W-1:0]  wp_y;
    logic signed [wpi_pkg::COORD_W-1:0]  wp_z;

    modport source (output valid, kind, waypoint_index, wp_x, wp_y, wp_z, input ready);
    modport sink   (input valid, kind, waypoint_index, wp_x, wp_y, wp_z, output ready);
endinterface

// ===== rtl/wpi_rsp_if.sv =====
interface wpi_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [wpi_pkg::COORD_W-1:0]  pos_x;
    logic signed [wpi_pkg::COORD_W-1:0]  pos_y;
    logic signed [wpi_pkg::COORD_W-1:0]  pos_z;
    logic [wpi_pkg::STATUS_W-1:0]        status;
    logic [wpi_pkg::ADDR_W-1:0]          reached_index;

    modport source (output valid, pos_x, pos_y, pos_z, status, reached_index, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, status, reached_index, output ready);
endinterface

// ===== rtl/wpi_ram.sv =====
module wpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wpi_mul.sv =====
module wpi_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wpi_pkg::MAG_W-1:0]   a,
    input  logic [wpi_pkg::MAG_W-1:0]   b,
    output logic                        done,
    output logic [wpi_pkg::PROD_W-1:0]  prod
);

    localparam int CW = $clog2(wpi_pkg::MAG_W + 1);

    logic [wpi_pkg::PROD_W-1:0] mcand_reg;
    logic [wpi_pkg::MAG_W-1:0]  mplier_reg;
    logic [wpi_pkg::PROD_W-1:0] prod_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    // control: one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(wpi_pkg::MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= wpi_pkg::PROD_W'(a);
            mplier_reg <= b;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/wpi_sqrt.sv =====
module wpi_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wpi_pkg::PROD_W-1:0]  rad,
    output logic                        done,
    output logic [wpi_pkg::ROOT_W-1:0]  root
);

    localparam int REM_W = wpi_pkg::ROOT_W + 3;
    localparam int CW    = $clog2(wpi_pkg::ROOT_W + 1);

    logic [wpi_pkg::PROD_W-1:0] rad_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [wpi_pkg::ROOT_W-1:0] root_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // two radicand bits per cycle, one root bit out
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[wpi_pkg::PROD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(wpi_pkg::ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[wpi_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/wpi_div.sv =====
module wpi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wpi_pkg::QUO_W-1:0]   num,
    input  logic [wpi_pkg::ROOT_W-1:0]  den,
    output logic                        done,
    output logic [wpi_pkg::QUO_W-1:0]   quo
);

    localparam int REM_W = wpi_pkg::ROOT_W + 1;
    localparam int CW    = $clog2(wpi_pkg::QUO_W + 1);

    logic [wpi_pkg::QUO_W-1:0]  quo_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [wpi_pkg::ROOT_W-1:0] den_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [REM_W-1:0] rem_sh;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-2:0], quo_reg[wpi_pkg::QUO_W-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(wpi_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[wpi_pkg::QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/waypoint_path_interpolator_core.sv =====
// Load, restart and unused requests give no response.
// A step request runs the bit-serial multiplier (per square and per |d|*step),
// the square root and the divider per axis, one request at a time; when a
// waypoint is reached, the next one is read and the pass is repeated.
// Reset (async, active low) loads register defaults, position 0, target 0;
// the waypoint store is not cleared.
module waypoint_path_interpolator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpi_pkg::CFG_DATA_W-1:0]    cfg_data,
    wpi_cmd_if.sink                           cmd,
    wpi_rsp_if.source                         rsp
);

    localparam int AW = wpi_pkg::ADDR_W;
    localparam int CW = wpi_pkg::COORD_W;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_READ    = 13'b0000000000010,
        S_LOAD    = 13'b0000000000100,
        S_SQ_GO   = 13'b0000000001000,
        S_SQ_WAIT = 13'b0000000010000,
        S_RT_GO   = 13'b0000000100000,
        S_RT_WAIT = 13'b0000001000000,
        S_CHECK   = 13'b0000010000000,
        S_MV_GO   = 13'b0000100000000,
        S_MV_WAIT = 13'b0001000000000,
        S_DV_GO   = 13'b0010000000000,
        S_DV_WAIT = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [CW-1:0]          start_reg [3];
    logic [wpi_pkg::STEP_W-1:0]    step_reg;
    logic [wpi_pkg::CNT_W-1:0]     count_reg;

    // walk state
    logic signed [CW-1:0]          cur_reg [3];
    logic [AW-1:0]                 target_reg;
    logic [AW-1:0]                 slot_reg;
    logic                          phase_reg;
    logic signed [CW-1:0]          tgt_reg [3];
    logic [wpi_pkg::MAG_W-1:0]     mag_reg [3];
    logic                          neg_reg [3];
    logic [wpi_pkg::PROD_W-1:0]    acc_reg;
    logic [wpi_pkg::ROOT_W-1:0]    len_reg;
    logic [1:0]                    ax_reg;
    wpi_pkg::status_t              status_reg;
    logic [AW-1:0]                 reached_reg;

    // response register
    logic                          out_vld_reg;
    logic signed [CW-1:0]          out_pos_reg [3];
    wpi_pkg::status_t              out_status_reg;
    logic [AW-1:0]                 out_reached_reg;

    logic                          accept;
    logic [AW-1:0]                 last;
    logic [wpi_pkg::ENTRY_W-1:0]   rdata;
    logic                          mul_start, mul_done, rt_start, rt_done, dv_start, dv_done;
    logic [wpi_pkg::MAG_W-1:0]     mul_b;
    logic [wpi_pkg::PROD_W-1:0]    prod;
    logic [wpi_pkg::ROOT_W-1:0]    root;
    logic [wpi_pkg::QUO_W-1:0]     quo;
    logic [wpi_pkg::QC_W-1:0]      qc;
    logic signed [wpi_pkg::NV_W-1:0] nv;
    logic signed [CW-1:0]          nv_sat;
    logic signed [CW:0]            d [3];
    logic signed [CW-1:0]          rd_coord [3];

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // index of the last waypoint in use
    always_comb
    begin
        if (count_reg == '0)
        begin
            last = '0;
        end
        else if (count_reg > wpi_pkg::CNT_W'(wpi_pkg::WAYPOINTS))
        begin
            last = AW'(wpi_pkg::WAYPOINTS - 1);
        end
        else
        begin
            last = AW'(count_reg - wpi_pkg::CNT_W'(1));
        end
    end

    // differences to the target just read
    always_comb
    begin
        rd_coord[0] = rdata[CW-1:0];
        rd_coord[1] = rdata[2*CW-1:CW];
        rd_coord[2] = rdata[3*CW-1:2*CW];
        for (int i = 0; i < 3; i++)
        begin
            d[i] = (CW+1)'(rd_coord[i]) - (CW+1)'(cur_reg[i]);
        end
    end

    // move of the current axis, clamped and saturated
    always_comb
    begin
        qc = (quo > wpi_pkg::QUO_W'(wpi_pkg::MOVE_CAP)) ? wpi_pkg::MOVE_CAP
                                                         : wpi_pkg::QC_W'(quo);
        if (neg_reg[ax_reg])
        begin
            nv = wpi_pkg::NV_W'(cur_reg[ax_reg]) - $signed({2'b00, qc});
        end
        else
        begin
            nv = wpi_pkg::NV_W'(cur_reg[ax_reg]) + $signed({2'b00, qc});
        end
        if (nv > $signed(wpi_pkg::NV_W'(32'h7FFF_FFFF)))
        begin
            nv_sat = 32'sh7FFF_FFFF;
        end
        else if (nv < -$signed(wpi_pkg::NV_W'(32'h8000_0000)))
        begin
            nv_sat = 32'sh8000_0000;
        end
        else
        begin
            nv_sat = CW'(nv);
        end
    end

    assign mul_start = (state_reg == S_SQ_GO) || (state_reg == S_MV_GO);
    assign mul_b     = (state_reg == S_SQ_GO) ? mag_reg[ax_reg]
                                              : wpi_pkg::MAG_W'(step_reg);
    assign rt_start  = (state_reg == S_RT_GO);
    assign dv_start  = (state_reg == S_DV_GO);

    wpi_ram #(
        .WIDTH (wpi_pkg::ENTRY_W),
        .DEPTH (wpi_pkg::WAYPOINTS)
    ) u_store (
        .clk   (clk),
        .we    (accept && (cmd.kind == wpi_pkg::KIND_LOAD)),
        .waddr (cmd.waypoint_index),
        .wdata ({cmd.wp_z, cmd.wp_y, cmd.wp_x}),
        .re    (state_reg == S_READ),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    wpi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag_reg[ax_reg]),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    wpi_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_start),
        .rad   (acc_reg),
        .done  (rt_done),
        .root  (root)
    );

    wpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (prod[wpi_pkg::QUO_W-1:0]),
        .den   (len_reg),
        .done  (dv_done),
        .quo   (quo)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg[0] <= '0;
            start_reg[1] <= '0;
            start_reg[2] <= '0;
            step_reg     <= wpi_pkg::STEP_RESET;
            count_reg    <= wpi_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wpi_pkg::REG_START_X: start_reg[0] <= cfg_data;
                wpi_pkg::REG_START_Y: start_reg[1] <= cfg_data;
                wpi_pkg::REG_START_Z: start_reg[2] <= cfg_data;
                wpi_pkg::REG_STEP:    step_reg     <= cfg_data[wpi_pkg::STEP_W-1:0];
                wpi_pkg::REG_COUNT:   count_reg    <= cfg_data[wpi_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_reg[0]  <= '0;
            cur_reg[1]  <= '0;
            cur_reg[2]  <= '0;
            target_reg  <= '0;
            slot_reg    <= '0;
            phase_reg   <= 1'b0;
            ax_reg      <= '0;
            status_reg  <= wpi_pkg::ST_MOVING;
            reached_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            // response taken; S_OUT below decides on its own
            if (rsp.ready && (state_reg != S_OUT))
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.kind)
                            wpi_pkg::KIND_RESTART:
                            begin
                                cur_reg    <= start_reg;
                                target_reg <= '0;
                            end
                            wpi_pkg::KIND_STEP:
                            begin
                                slot_reg    <= (target_reg > last) ? last : target_reg;
                                phase_reg   <= 1'b0;
                                status_reg  <= wpi_pkg::ST_MOVING;
                                reached_reg <= '0;
                                state_reg   <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        tgt_reg[i] <= rd_coord[i];
                        neg_reg[i] <= d[i][CW];
                        mag_reg[i] <= d[i][CW] ? wpi_pkg::MAG_W'(-d[i])
                                               : wpi_pkg::MAG_W'(d[i]);
                    end
                    acc_reg   <= '0;
                    ax_reg    <= '0;
                    state_reg <= S_SQ_GO;
                end
                S_SQ_GO:
                begin
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= acc_reg + prod;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_RT_GO;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_SQ_GO;
                        end
                    end
                end
                S_RT_GO:
                begin
                    state_reg <= S_RT_WAIT;
                end
                S_RT_WAIT:
                begin
                    if (rt_done)
                    begin
                        len_reg   <= root;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // distance below twice the step: isqrt(S) < 2*step
                    if (!phase_reg && (len_reg < {1'b0, step_reg, 1'b0}))
                    begin
                        if (slot_reg >= last)
                        begin
                            status_reg <= wpi_pkg::ST_FINISHED;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            cur_reg     <= tgt_reg;
                            status_reg  <= wpi_pkg::ST_REACHED;
                            reached_reg <= slot_reg;
                            slot_reg    <= slot_reg + AW'(1);
                            target_reg  <= slot_reg + AW'(1);
                            phase_reg   <= 1'b1;
                            state_reg   <= S_READ;
                        end
                    end
                    else if (len_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_MV_GO;
                    end
                end
                S_MV_GO:
                begin
                    state_reg <= S_MV_WAIT;
                end
                S_MV_WAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_DV_GO;
                    end
                end
                S_DV_GO:
                begin
                    state_reg <= S_DV_WAIT;
                end
                S_DV_WAIT:
                begin
                    if (dv_done)
                    begin
                        cur_reg[ax_reg] <= nv_sat;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_MV_GO;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_vld_reg || rsp.ready)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!out_vld_reg || rsp.ready))
        begin
            out_pos_reg     <= cur_reg;
            out_status_reg  <= status_reg;
            out_reached_reg <= reached_reg;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.pos_x         = out_pos_reg[0];
    assign rsp.pos_y         = out_pos_reg[1];
    assign rsp.pos_z         = out_pos_reg[2];
    assign rsp.status        = out_status_reg;
    assign rsp.reached_index = out_reached_reg;

endmodule
